// ===== rtl/fts_pkg.sv =====
// shared types, constants and event codes for the fair task scheduler
package fts_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam logic [2:0] OP_WAKE      = 3'd0;
    localparam logic [2:0] OP_TICK      = 3'd1;
    localparam logic [2:0] OP_YIELD     = 3'd2;
    localparam logic [2:0] OP_SUSPEND   = 3'd3;
    localparam logic [2:0] OP_TERMINATE = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IDLE    = 2'd1;
    localparam logic [1:0] ST_ALREADY = 2'd2;
    localparam logic [1:0] ST_BADOP   = 2'd3;

    localparam logic [31:0] CYCLES_PER_US_RST = 32'd1000;
    localparam logic [31:0] MIN_SLICE_RST     = 32'd10000;
    localparam logic [31:0] DEFAULT_SLICE_RST = 32'd20000;

    // register indexes on the configuration port
    localparam logic [1:0] REG_CYCLES  = 2'd0;
    localparam logic [1:0] REG_MIN     = 2'd1;
    localparam logic [1:0] REG_DEFAULT = 2'd2;

    // command from the controller to every cell in the row
    typedef struct packed {
        logic       clear_all;  // drop the running best of the scan
        logic       scan;       // shift the candidate one cell along
    } fts_cell_cmd_t;

endpackage

// ===== rtl/fts_divider.sv =====
// 64 by 32 bit restoring divider, one quotient bit per cycle
module fts_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] trial;

    assign trial    = {rem_reg[31:0], quo_reg[63]};
    assign done     = busy_reg && (cnt_reg == 7'd0);
    assign quotient = quo_reg;

    // shift and subtract step
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        dvs_next  = dvs_reg;
        if (go)
        begin
            quo_next  = dividend;
            rem_next  = 33'd0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'd0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 7'd1;
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_next = trial - {1'b0, dvs_reg};
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

// ===== rtl/fts_cell.sv =====
// one cell of the minimum search row: keeps the best candidate seen so far
module fts_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fts_pkg::fts_cell_cmd_t cmd,
    input  logic                  in_valid,
    input  logic [63:0]           in_key,
    input  logic [7:0]            in_id,
    output logic                  out_valid,
    output logic [63:0]           out_key,
    output logic [7:0]            out_id
);

    logic        v_reg;
    logic [63:0] k_reg;
    logic [7:0]  i_reg;
    logic        take;

    // candidate replaces held one when strictly smaller, so earlier ids win ties
    assign take = in_valid && (!v_reg || in_key < k_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (cmd.clear_all)
        begin
            v_reg <= 1'b0;
        end
        else if (cmd.scan && take)
        begin
            v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan && take)
        begin
            k_reg <= in_key;
            i_reg <= in_id;
        end
    end

    assign out_valid = v_reg;
    assign out_key   = k_reg;
    assign out_id    = i_reg;

endmodule

// ===== rtl/fair_task_scheduler.sv =====
// fair task scheduler top level: event sequencer, task tables, search row, divider
//
// An event lasts from the start transfer to the end of its result strobe; a bad operation is
// the shortest and a timer tick the longest. A bad operation goes straight to the result,
// other rejected events pass the decode state first, and a wake while a task runs passes the
// decode, read and wake states. The table scan walks MAX_TASKS entries one a cycle, plus a drain
// step, through a two cell search row that keeps the least and the next-least queued task. Both
// 64-bit divisions (idle level share, timeslice) run in one shared bit-serial divider, so a tick can use it twice.
// busy is high from the cycle after the accepted start through the result strobe; the
// result is shown for exactly one cycle and cannot be held off, so the receiver must take
// it then.
module fair_task_scheduler #(
    parameter int MAX_TASKS = fts_pkg::MAX_TASKS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic [3:0]  task_id,
    input  logic        fresh,
    input  logic [47:0] elapsed,
    output logic        done,
    output logic        running,
    output logic [3:0]  run_task,
    output logic        dispatched,
    output logic        slice_valid,
    output logic [31:0] slice_us,
    output logic [1:0]  status
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_WAKE   = 4'd2;
    localparam logic [3:0] S_CHDIV  = 4'd3;
    localparam logic [3:0] S_CHARGE = 4'd4;
    localparam logic [3:0] S_SCAN   = 4'd5;
    localparam logic [3:0] S_PICK   = 4'd6;
    localparam logic [3:0] S_SLDIV  = 4'd7;
    localparam logic [3:0] S_SLWAIT = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;
    localparam logic [3:0] S_RD     = 4'd10;

    // configuration registers
    logic [31:0] cyc_reg, min_reg, def_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc_reg <= fts_pkg::CYCLES_PER_US_RST;
            min_reg <= fts_pkg::MIN_SLICE_RST;
            def_reg <= fts_pkg::DEFAULT_SLICE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                fts_pkg::REG_CYCLES:  cyc_reg <= pwdata;
                fts_pkg::REG_MIN:     min_reg <= pwdata;
                fts_pkg::REG_DEFAULT: def_reg <= pwdata;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            fts_pkg::REG_CYCLES:  prdata = cyc_reg;
            fts_pkg::REG_MIN:     prdata = min_reg;
            fts_pkg::REG_DEFAULT: prdata = def_reg;
            default:              prdata = 32'd0;
        endcase
    end

    // task tables: unfairness and idle mark are written through one port each
    logic [63:0] unf_mem [MAX_TASKS];
    logic [63:0] mark_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] queued_reg;
    logic [MAX_TASKS-1:0] touched_reg;

    logic [3:0]    state_reg;
    logic [2:0]    op_reg;
    logic [IW-1:0] tid_reg;
    logic          fresh_reg;
    logic [47:0]   el_reg;
    logic          cur_v_reg;
    logic [IW-1:0] cur_id_reg;
    logic [CW-1:0] cnt_reg;
    logic [63:0]   idle_reg;
    logic [IW:0]   scan_reg;
    logic          disp_reg, sv_reg;
    logic [31:0]   slice_reg;
    logic [1:0]    st_reg;
    logic [IW-1:0] old_id_reg;
    logic [63:0]   rd_unf, rd_mark;
    logic [63:0]   cur_unf_reg;

    // registered table read at the address chosen by the sequencer
    logic [IW-1:0] rd_addr;
    always_ff @(posedge clk)
    begin
        rd_unf  <= touched_reg[rd_addr] ? unf_mem[rd_addr] : 64'd0;
        rd_mark <= touched_reg[rd_addr] ? mark_mem[rd_addr] : 64'd0;
    end

    // search row of two cells: least and next-least queued task
    fts_pkg::fts_cell_cmd_t cmd;
    logic        c0_v, c1_v;
    logic [63:0] c0_k, c1_k;
    logic [7:0]  c0_i, c1_i;
    logic        feed_v;
    logic [7:0]  feed_id;
    logic        c1_in_v;
    logic [63:0] c1_in_k;
    logic [7:0]  c1_in_i;
    logic        bump;

    // the displaced first-place candidate moves on to the second cell
    assign bump    = feed_v && c0_v && (rd_unf < c0_k);
    assign c1_in_v = bump ? 1'b1 : feed_v;
    assign c1_in_k = bump ? c0_k : rd_unf;
    assign c1_in_i = bump ? c0_i : feed_id;

    fts_cell u_cell0 (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_valid(feed_v), .in_key(rd_unf), .in_id(feed_id),
        .out_valid(c0_v), .out_key(c0_k), .out_id(c0_i)
    );

    fts_cell u_cell1 (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_valid(c1_in_v && !(feed_v && !bump && !c0_v)), .in_key(c1_in_k),
        .in_id(c1_in_i),
        .out_valid(c1_v), .out_key(c1_k), .out_id(c1_i)
    );

    // shared divider
    logic        div_go, div_done;
    logic [63:0] div_a, div_q;
    logic [31:0] div_b;

    fts_divider u_div (
        .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(div_a), .divisor(div_b),
        .done(div_done), .quotient(div_q)
    );

    logic [IW-1:0] scan_idx;
    logic          scan_valid_reg;
    logic [IW-1:0] scan_idx_reg;
    assign scan_idx = scan_reg[IW-1:0];

    always_comb
    begin
        rd_addr = tid_reg;
        if (state_reg == S_SCAN)
        begin
            rd_addr = scan_idx;
        end
        else if (state_reg == S_CHDIV || state_reg == S_CHARGE || state_reg == S_PICK)
        begin
            rd_addr = cur_id_reg;
        end
    end

    assign feed_v  = (state_reg == S_SCAN) && scan_valid_reg;
    assign feed_id = 8'(scan_idx_reg);
    assign cmd.scan      = (state_reg == S_SCAN);
    assign cmd.clear_all = (state_reg == S_DECODE);

    // the divider for the slice takes the gap to the next-least task
    logic [63:0] nxt_key_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_PICK)
        begin
            nxt_key_reg <= c1_k;
        end
    end

    logic [63:0] gap;
    logic [63:0] us_floor;
    assign gap      = nxt_key_reg - cur_unf_reg;
    assign us_floor = (div_q <= {32'd0, min_reg}) ? {32'd0, min_reg} : div_q;

    assign div_go = (state_reg == S_CHDIV && cnt_reg != '0)
                 || (state_reg == S_SLDIV && c1_v && cyc_reg != 32'd0);
    assign div_a  = (state_reg == S_CHDIV) ? {16'd0, el_reg} : gap;
    assign div_b  = (state_reg == S_CHDIV) ? 32'(cnt_reg) : cyc_reg;

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_OUT;
    assign running     = cur_v_reg;
    assign run_task    = cur_v_reg ? 4'(cur_id_reg) : 4'd0;
    assign dispatched  = disp_reg;
    assign slice_valid = sv_reg;
    assign slice_us    = sv_reg ? slice_reg : 32'd0;
    assign status      = st_reg;

    logic [IW:0] last_idx;
    assign last_idx = (IW+1)'(MAX_TASKS);

    // event sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            queued_reg  <= '0;
            touched_reg <= '0;
            cur_v_reg   <= 1'b0;
            cur_id_reg  <= '0;
            cnt_reg     <= '0;
            idle_reg    <= 64'd0;
            disp_reg    <= 1'b0;
            sv_reg      <= 1'b0;
            st_reg      <= fts_pkg::ST_OK;
            scan_reg    <= '0;
            scan_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= operation;
                        tid_reg   <= IW'(task_id);
                        fresh_reg <= fresh;
                        el_reg    <= elapsed;
                        disp_reg  <= 1'b0;
                        sv_reg    <= 1'b0;
                        st_reg    <= fts_pkg::ST_OK;
                        old_id_reg <= cur_id_reg;
                        if (operation > fts_pkg::OP_TERMINATE
                            || (operation == fts_pkg::OP_WAKE
                                && 32'(task_id) >= 32'(MAX_TASKS)))
                        begin
                            st_reg    <= fts_pkg::ST_BADOP;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_DECODE;
                        end
                    end
                end
                S_DECODE:
                begin
                    if (op_reg == fts_pkg::OP_WAKE)
                    begin
                        if (queued_reg[tid_reg] || (cur_v_reg && cur_id_reg == tid_reg))
                        begin
                            st_reg    <= fts_pkg::ST_ALREADY;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                    else if (!cur_v_reg)
                    begin
                        st_reg    <= fts_pkg::ST_IDLE;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_CHDIV;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_WAKE;
                end
                S_WAKE:
                begin
                    // catch up with the idle level since the task last slept
                    unf_mem[tid_reg]  <= (fresh_reg ? 64'd0 : rd_unf)
                                       + idle_reg - (fresh_reg ? 64'd0 : rd_mark);
                    mark_mem[tid_reg] <= fresh_reg ? 64'd0 : rd_mark;
                    touched_reg[tid_reg] <= 1'b1;
                    if (cnt_reg != CW'(MAX_TASKS))
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    queued_reg[tid_reg] <= 1'b1;
                    if (!cur_v_reg)
                    begin
                        disp_reg  <= 1'b1;
                        sv_reg    <= 1'b1;
                        scan_reg  <= '0;
                        scan_valid_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_CHDIV:
                begin
                    state_reg <= S_CHARGE;
                end
                S_CHARGE:
                begin
                    if (cnt_reg == '0 || div_done)
                    begin
                        unf_mem[cur_id_reg]  <= rd_unf + {16'd0, el_reg};
                        mark_mem[cur_id_reg] <= (op_reg == fts_pkg::OP_SUSPEND)
                            ? idle_reg + ((cnt_reg == '0) ? 64'd0 : div_q) : rd_mark;
                        touched_reg[cur_id_reg] <= 1'b1;
                        if (cnt_reg != '0)
                        begin
                            idle_reg <= idle_reg + div_q;
                        end
                        if (op_reg == fts_pkg::OP_TICK || op_reg == fts_pkg::OP_YIELD)
                        begin
                            queued_reg[cur_id_reg] <= 1'b1;
                            sv_reg <= (op_reg == fts_pkg::OP_TICK);
                        end
                        else if (cnt_reg != '0)
                        begin
                            cnt_reg <= cnt_reg - CW'(1);
                        end
                        scan_reg  <= '0;
                        scan_valid_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // table read is registered, so the index and its valid flag are registered to match
                    scan_idx_reg   <= scan_idx;
                    scan_valid_reg <= (scan_reg != last_idx) && queued_reg[scan_idx];
                    if (scan_reg == last_idx)
                    begin
                        state_reg <= S_PICK;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + (IW+1)'(1);
                    end
                end
                S_PICK:
                begin
                    if (!c0_v)
                    begin
                        cur_v_reg  <= 1'b0;
                        cur_id_reg <= '0;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        cur_v_reg  <= 1'b1;
                        cur_id_reg <= IW'(c0_i);
                        queued_reg[IW'(c0_i)] <= 1'b0;
                        cur_unf_reg <= c0_k;
                        if (op_reg != fts_pkg::OP_WAKE)
                        begin
                            disp_reg <= !cur_v_reg || (IW'(c0_i) != old_id_reg)
                                || op_reg == fts_pkg::OP_SUSPEND
                                || op_reg == fts_pkg::OP_TERMINATE;
                        end
                        state_reg <= sv_reg ? S_SLDIV : S_OUT;
                    end
                end
                S_SLDIV:
                begin
                    // next-least key was taken from the second cell at the pick
                    if (!c1_v)
                    begin
                        slice_reg <= def_reg;
                        state_reg <= S_OUT;
                    end
                    else if (cyc_reg == 32'd0)
                    begin
                        slice_reg <= 32'hFFFF_FFFF;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_SLWAIT;
                    end
                end
                S_SLWAIT:
                begin
                    if (div_done)
                    begin
                        slice_reg <= (us_floor[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                   : us_floor[31:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result outside a busy window");
    a_slice_run: assert property (@(posedge clk) disable iff (!rst_n)
        (done && slice_valid) |-> running)
        else $error("slice armed with no running task");

endmodule
